// ===== hdl/fffs_pkg.sv =====
`default_nettype none
package fffs_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int VAL_W     = 24;
	localparam int SLOT_IDX_W = 4;
	localparam int STAT_W    = 2;

	// occupancy is searched one chunk of slots per cycle
	localparam int CHUNK     = 16;
	localparam int OFF_W     = 4;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// occupancy update from the controller
	typedef struct packed {
		logic en;
		logic occupied;
	} occ_upd_t;

	// search result for the current chunk
	typedef struct packed {
		logic             found;
		logic [OFF_W-1:0] offset;
	} occ_hit_t;

endpackage
`default_nettype wire

// ===== hdl/fffs_slot_mem.sv =====
`default_nettype none
module fffs_slot_mem import fffs_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	parameter int IDX_W = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire logic [VAL_W-1:0] wdata,
	input  wire logic [IDX_W-1:0] raddr,
	output logic      [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/fffs_occ.sv =====
`default_nettype none
module fffs_occ import fffs_pkg::*; #(
	parameter int SLOTS  = SLOTS_DEF,
	parameter int IDX_W  = 4,
	parameter int CHUNKS = 1,
	parameter int CW     = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CW-1:0]    chunk,
	input  wire logic             want_full,
	input  wire occ_upd_t         upd,
	input  wire logic [IDX_W-1:0] upd_idx,
	output occ_hit_t              hit
);

	localparam int PAD = CHUNKS * CHUNK;

	logic [SLOTS-1:0] occ_q;
	logic [PAD-1:0]   occ_pad;
	logic [PAD-1:0]   valid_pad;
	logic [PAD-1:0]   match;
	logic [CHUNK-1:0] sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (upd.en) begin
			occ_q[upd_idx] <= upd.occupied;
		end
	end

	// slots past the end never match
	assign occ_pad   = PAD'(occ_q);
	assign valid_pad = PAD'({SLOTS{1'b1}});
	assign match     = valid_pad & (want_full ? occ_pad : ~occ_pad);
	assign sel       = match[chunk*CHUNK +: CHUNK];

	// lowest matching slot in the chunk
	always_comb begin
		hit = '0;
		for (int i = CHUNK - 1; i >= 0; i--) begin
			if (sel[i]) begin
				hit.found  = 1'b1;
				hit.offset = OFF_W'(i);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/first_free_slot_buffer.sv =====
// First-free slot buffer. Requests are taken with start while busy is low:
// an insert puts item_value in the lowest empty slot, a remove takes the value
// from the lowest occupied slot and empties it. A zero value marks a slot as
// empty, so inserting zero reports done but leaves the slot free. Every
// request gives exactly one result, shown for a single cycle with done high;
// there is no backpressure, so the receiver must take it in that cycle.
// The values live in a one-port-read synchronous memory, and a flop per slot
// records occupancy. That occupancy is searched 16 slots per cycle; an
// insert or a failed request keeps busy high while its chunks are scanned,
// and a remove then passes through S_READ for the memory read; done follows the last
// busy cycle, and busy is already low while done is high, so the next start
// can be taken at the edge that ends the done cycle.
`default_nettype none
module first_free_slot_buffer import fffs_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  req_type,
	input  wire logic [VAL_W-1:0]      item_value,
	output logic                       done,
	output logic [STAT_W-1:0]          status,
	output logic [SLOT_IDX_W-1:0]      slot_index,
	output logic [VAL_W-1:0]           removed_value
);

	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CHUNKS = (SLOTS + CHUNK - 1) / CHUNK;
	localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int POS_W  = CW + OFF_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_READ = 3'b100
	} state_t;

	state_t state_q;

	// latched request
	logic             req_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0]    chunk_q;

	// result registers
	logic                  done_q;
	logic [STAT_W-1:0]     status_q;
	logic [SLOT_IDX_W-1:0] index_q;
	logic [VAL_W-1:0]      removed_q;

	occ_hit_t         hit;
	occ_upd_t         upd;
	logic [POS_W-1:0] pos;
	logic [IDX_W-1:0] pos_idx;
	logic             last_chunk;
	logic             mem_we;
	logic [VAL_W-1:0] rdata;

	assign pos        = {chunk_q, hit.offset};
	assign pos_idx    = pos[IDX_W-1:0];
	assign last_chunk = (chunk_q == CW'(CHUNKS - 1));

	// an insert looks for an empty slot, a remove for an occupied one
	fffs_occ #(
		.SLOTS  (SLOTS),
		.IDX_W  (IDX_W),
		.CHUNKS (CHUNKS),
		.CW     (CW)
	) u_occ (
		.clk       (clk),
		.arst_n    (arst_n),
		.chunk     (chunk_q),
		.want_full (req_q == REQ_REMOVE),
		.upd       (upd),
		.upd_idx   (pos_idx),
		.hit       (hit)
	);

	// occupancy changes on a hit: insert marks the slot by its value,
	// remove frees it
	always_comb begin
		upd          = '0;
		upd.en       = (state_q == S_SCAN) && hit.found;
		upd.occupied = (req_q == REQ_INSERT) && (val_q != '0);
	end

	assign mem_we = (state_q == S_SCAN) && hit.found && (req_q == REQ_INSERT);

	// the read address follows the search; on a remove hit the data is
	// back in the next cycle. a write and a read of the same slot never
	// overlap since a new request is only taken from idle
	fffs_slot_mem #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (pos_idx),
		.wdata (val_q),
		.raddr (pos_idx),
		.rdata (rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chunk_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						chunk_q <= '0;
					end
				end
				S_SCAN: begin
					if (hit.found) begin
						if (req_q == REQ_REMOVE) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end else if (last_chunk) begin
						// no slot found: full or empty
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						chunk_q <= chunk_q + CW'(1);
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			req_q <= req_type;
			val_q <= item_value;
		end
		if (state_q == S_SCAN) begin
			if (hit.found) begin
				status_q  <= ST_DONE;
				index_q   <= pos[SLOT_IDX_W-1:0];
				removed_q <= '0;
			end else if (last_chunk) begin
				status_q  <= (req_q == REQ_REMOVE) ? ST_EMPTY : ST_FULL;
				index_q   <= '0;
				removed_q <= '0;
			end
		end
		if (state_q == S_READ) begin
			removed_q <= rdata;
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign slot_index    = index_q;
	assign removed_value = removed_q;

endmodule
`default_nettype wire
